@@ hw/rtl/cnas_pkg.sv @@
// shared types, constants and helper functions for the cpio newc archive scanner
package cnas_pkg;

  // header layout
  localparam int unsigned HEADER_BYTES = 110;
  localparam int unsigned DATA_ALIGN   = 4;    // power of two
  localparam int unsigned FSIZE_AT     = 54;
  localparam int unsigned NSIZE_AT     = 94;
  localparam int unsigned HEX_DIGITS   = 8;

  localparam logic [6:0] HDR_LAST   = 7'(HEADER_BYTES - 1);
  localparam logic [6:0] FSIZE_LO   = 7'(FSIZE_AT);
  localparam logic [6:0] FSIZE_HI   = 7'(FSIZE_AT + HEX_DIGITS - 1);
  localparam logic [6:0] NSIZE_LO   = 7'(NSIZE_AT);
  localparam logic [6:0] NSIZE_HI   = 7'(NSIZE_AT + HEX_DIGITS - 1);
  localparam logic [33:0] HDR_LEN34 = 34'(HEADER_BYTES);
  localparam logic [33:0] ALIGN_M1  = 34'(DATA_ALIGN - 1);

  // name table: trailer first, then the six target paths
  localparam int unsigned NAME_COUNT = 7;
  localparam int unsigned NAME_MAX   = 34;
  localparam logic [31:0] VND = 32'h6f72_6361;

  localparam logic [NAME_MAX*8-1:0] NAME_TBL [NAME_COUNT] = '{
    {"TRAILER!!!", {(NAME_MAX-10){8'h00}}},
    {"init", {(NAME_MAX-4){8'h00}}},
    {"usr/share/", VND, "/rootfs.manifest", {(NAME_MAX-30){8'h00}}},
    {"etc/", VND, "/ai/config.yaml", {(NAME_MAX-23){8'h00}}},
    {"etc/", VND, "/network/", VND, "-net.conf", {(NAME_MAX-30){8'h00}}},
    {"etc/", VND, "/updater/ota.conf", {(NAME_MAX-25){8'h00}}},
    {"etc/", VND, "/system/init/profile.conf", {(NAME_MAX-33){8'h00}}}
  };
  localparam logic [5:0] NAME_LEN [NAME_COUNT] = '{
    6'd10, 6'd4, 6'd30, 6'd23, 6'd30, 6'd25, 6'd33
  };

  // record kinds
  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // one result record
  typedef struct packed {
    logic        kind;
    logic [2:0]  file_id;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic        trailer_ok;
    logic [31:0] entries_seen;
    logic        init_found;
    logic        manifest_found;
    logic [7:0]  captured_count;
    logic        last;
  } rec_t;

  // records produced by one input beat
  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  // hex digit decode: {ok, value}
  function automatic logic [4:0] hex_dec(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
    return r;
  endfunction

  // character of a table name at a position, NUL past its end
  function automatic logic [7:0] name_char(input int k, input logic [5:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (idx < 6'(NAME_MAX)) c = NAME_TBL[k][(NAME_MAX - 1 - int'(idx)) * 8 +: 8];
    return c;
  endfunction

  // round up to the data alignment
  function automatic logic [33:0] align_up(input logic [33:0] x);
    return (x + ALIGN_M1) & ~ALIGN_M1;
  endfunction

endpackage

@@ hw/rtl/cnas_core.sv @@
// per-byte scan state machine: header parse, name match, skip and record build
module cnas_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              in_acc,
  input  logic              in_op,
  input  logic [7:0]        in_byte,
  output cnas_pkg::push_t   push
);
  import cnas_pkg::*;

  typedef enum logic [1:0] {PH_STOPPED, PH_HEADER, PH_NAME, PH_SKIP} phase_t;

  phase_t      phase, phase_next;
  logic [31:0] arch_len;
  logic [31:0] pos, pos_next;
  logic [6:0]  hidx, hidx_next;
  logic [31:0] flen, flen_next;
  logic [31:0] nlen, nlen_next;
  logic [31:0] skip, skip_next;
  logic [6:0]  flags, flags_next;
  logic [5:0]  nidx, nidx_next;
  logic [31:0] ents, ents_next;
  logic        init_seen, init_next;
  logic        man_seen, man_next;
  logic [7:0]  caps, caps_next;

  logic [33:0] lenx, e_w, fd_w, fe_w, nx_w, ee;
  logic [31:0] start;
  logic [4:0]  hv;
  logic [31:0] nl;
  logic [6:0]  fl;
  logic        fin, fin_ok, cap_v, do_end;
  logic [2:0]  cap_id;
  rec_t        cap_r, sum_r;

  // offsets used at the end of a name or a skip
  assign lenx  = {2'b0, arch_len};
  assign e_w   = {2'b0, pos} + 34'd1;
  assign fd_w  = align_up(e_w);
  assign fe_w  = fd_w + {2'b0, flen};
  assign nx_w  = align_up(fe_w);
  assign start = pos - {25'b0, hidx};
  assign hv    = hex_dec(in_byte);
  assign nl    = {nlen[27:0], hv[3:0]};

  // next state and records
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    hidx_next  = hidx;
    flen_next  = flen;
    nlen_next  = nlen;
    skip_next  = skip;
    flags_next = flags;
    nidx_next  = nidx;
    ents_next  = ents;
    init_next  = init_seen;
    man_next   = man_seen;
    caps_next  = caps;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    cap_v      = 1'b0;
    cap_id     = 3'd0;
    do_end     = 1'b0;
    ee         = '0;
    fl         = flags;
    if (in_acc) begin
      if (in_op) begin
        ents_next = '0;
        init_next = 1'b0;
        man_next  = 1'b0;
        caps_next = '0;
        pos_next  = '0;
        do_end    = 1'b1;
        ee        = '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            pos_next = pos + 32'd1;
            if (hidx < 7'd5) begin
              if (in_byte != (hidx[0] ? 8'h37 : 8'h30)) fin = 1'b1;
            end else if (hidx == 7'd5) begin
              if (in_byte != "1" && in_byte != "2") fin = 1'b1;
            end else if (hidx >= FSIZE_LO && hidx <= FSIZE_HI) begin
              if (!hv[4]) fin = 1'b1;
              flen_next = {flen[27:0], hv[3:0]};
            end else if (hidx >= NSIZE_LO && hidx <= NSIZE_HI) begin
              if (!hv[4]) fin = 1'b1;
              nlen_next = nl;
              if (hidx == NSIZE_HI) begin
                if (nl == 32'd0) fin = 1'b1;
                else if (({1'b0, arch_len} - {1'b0, start}) <
                         (33'(HEADER_BYTES) + {1'b0, nl})) fin = 1'b1;
                for (int k = 0; k < NAME_COUNT; k++) begin
                  if ({26'b0, NAME_LEN[k]} + 32'd1 != nl) flags_next[k] = 1'b0;
                end
              end
            end
            if (!fin) begin
              if (hidx >= HDR_LAST) begin
                phase_next = PH_NAME;
                skip_next  = nlen_next;
                nidx_next  = '0;
              end else begin
                hidx_next = hidx + 7'd1;
              end
            end
          end
          PH_NAME: begin
            pos_next = pos + 32'd1;
            for (int k = 0; k < NAME_COUNT; k++) begin
              if (!(nidx <= NAME_LEN[k] && in_byte == name_char(k, nidx))) fl[k] = 1'b0;
            end
            flags_next = fl;
            nidx_next  = (nidx == 6'h3f) ? nidx : nidx + 6'd1;
            skip_next  = skip - 32'd1;
            if (skip == 32'd1) begin
              ents_next = ents + 32'd1;
              if (fl[1]) init_next = 1'b1;
              if (fl[2]) man_next = 1'b1;
              if (fl[0]) begin
                fin    = 1'b1;
                fin_ok = 1'b1;
              end else if (fd_w > lenx || fe_w > lenx) begin
                fin = 1'b1;
              end else begin
                // lowest set target wins
                for (int k = NAME_COUNT - 1; k >= 1; k--) begin
                  if (fl[k]) begin
                    cap_v  = 1'b1;
                    cap_id = 3'(k - 1);
                  end
                end
                if (cap_v) caps_next = caps + 8'd1;
                if (nx_w > lenx) begin
                  fin = 1'b1;
                end else begin
                  skip_next = nx_w[31:0] - e_w[31:0];
                  if (nx_w == e_w) begin
                    do_end = 1'b1;
                    ee     = nx_w;
                  end else begin
                    phase_next = PH_SKIP;
                  end
                end
              end
            end
          end
          PH_SKIP: begin
            pos_next  = pos + 32'd1;
            skip_next = skip - 32'd1;
            if (skip == 32'd1) begin
              do_end = 1'b1;
              ee     = e_w;
            end
          end
          default: begin
          end
        endcase
      end
      // next entry start check
      if (do_end) begin
        if (ee + HDR_LEN34 > lenx) begin
          fin = 1'b1;
        end else begin
          phase_next = PH_HEADER;
          hidx_next  = '0;
          flen_next  = '0;
          nlen_next  = '0;
          skip_next  = '0;
          flags_next = '1;
        end
      end
      if (fin) phase_next = PH_STOPPED;
    end
  end

  // record assembly
  always_comb begin
    cap_r             = '0;
    cap_r.kind        = KIND_CAPTURE;
    cap_r.file_id     = cap_id;
    cap_r.data_offset = fd_w[31:0];
    cap_r.data_size   = flen;
    cap_r.last        = !fin;
    sum_r                = '0;
    sum_r.kind           = KIND_SUMMARY;
    sum_r.trailer_ok     = fin_ok;
    sum_r.entries_seen   = ents_next;
    sum_r.init_found     = init_next;
    sum_r.manifest_found = man_next;
    sum_r.captured_count = caps_next;
    sum_r.last           = 1'b1;
    push = '0;
    if (cap_v && fin) begin
      push.n  = 2'd2;
      push.r0 = cap_r;
      push.r1 = sum_r;
    end else if (cap_v) begin
      push.n  = 2'd1;
      push.r0 = cap_r;
    end else if (fin) begin
      push.n  = 2'd1;
      push.r0 = sum_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_STOPPED;
      arch_len  <= '0;
      pos       <= '0;
      hidx      <= '0;
      flen      <= '0;
      nlen      <= '0;
      skip      <= '0;
      flags     <= '1;
      nidx      <= '0;
      ents      <= '0;
      init_seen <= 1'b0;
      man_seen  <= 1'b0;
      caps      <= '0;
    end else begin
      if (cfg_wr_en) arch_len <= cfg_wr_data;
      phase     <= phase_next;
      pos       <= pos_next;
      hidx      <= hidx_next;
      flen      <= flen_next;
      nlen      <= nlen_next;
      skip      <= skip_next;
      flags     <= flags_next;
      nidx      <= nidx_next;
      ents      <= ents_next;
      init_seen <= init_next;
      man_seen  <= man_next;
      caps      <= caps_next;
    end
  end

  // a pair of records is always a capture then a summary
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.r0.kind == KIND_CAPTURE && push.r1.kind == KIND_SUMMARY)
    else $error("record pair out of order");

  // a summary stops the scan
  a_sum_stops: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd1 && push.r0.kind == KIND_SUMMARY) || push.n == 2'd2
      |=> phase == PH_STOPPED)
    else $error("scan kept running after summary");

  // name phase always has bytes left
  a_name_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NAME |-> skip != 32'd0)
    else $error("name phase with nothing left");

endmodule

@@ hw/rtl/cnas_outq.sv @@
// small result queue that takes up to two records a beat and hands out one
module cnas_outq #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  cnas_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output cnas_pkg::rec_t  out_rec
);
  import cnas_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  rec_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt != '0;
  assign out_rec   = mem[rp];
  assign room      = cnt <= (AW + 1)'(DEPTH - 2);

  // storage writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp] <= push.r0;
    if (push.n == 2'd2) mem[wp + AW'(1)] <= push.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + AW'(push.n);
      if (pop) rp <= rp + AW'(1);
      cnt <= cnt + (AW + 1)'(push.n) - (AW + 1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW + 1)'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> room)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !pop && push.n == 2'd0 |=> $stable(cnt))
    else $error("count moved while idle");

endmodule

@@ hw/rtl/cpio_newc_archive_scanner.sv @@
// cpio newc archive scanner top level
// a beat's records enter the result queue on acceptance and leave it in order;
// throughput is one archive byte per cycle while the queue has room, set by the
// single-pass byte logic, with up to two records per beat drained one per cycle
// while m_tready is high from an OUT_DEPTH-entry (default four) queue. synchronous
// active-high reset stops any scan, clears the archive length and empties the queue
module cpio_newc_archive_scanner #(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // file_id, data_offset, data_size, trailer_ok,
                                  // entries_seen, init_found, manifest_found,
                                  // captured_count, zero pad
  output logic         m_tuser,   // [0] record_kind
  output logic         m_tlast
);
  import cnas_pkg::*;

  push_t push;
  rec_t  rec;
  logic  room;

  assign s_tready = room;

  cnas_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_acc     (s_tvalid && s_tready),
    .in_op      (s_tuser),
    .in_byte    (s_tdata),
    .push       (push)
  );

  cnas_outq #(.DEPTH(OUT_DEPTH)) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_rec  (rec)
  );

  // output beat packing
  assign m_tdata = {2'b00, rec.captured_count, rec.manifest_found, rec.init_found,
                    rec.entries_seen, rec.trailer_ok, rec.data_size,
                    rec.data_offset, rec.file_id};
  assign m_tuser = rec.kind;
  assign m_tlast = rec.last;

endmodule
